// ===== src/lkvc_pkg.sv =====
package lkvc_pkg;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_INSERT = 1'b1;

   typedef struct packed {
      logic advance;
      logic insert_miss;
   } lkvc_ctl_type;

endpackage

// ===== src/lkvc_if.sv =====
interface lkvc_req_if #(
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32
);
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [KEY_BITS-1:0]   key;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, action, key, value, input ready);
   modport sink (input valid, action, key, value, output ready);
   modport monitor (input valid, ready, action, key, value);
endinterface

interface lkvc_rsp_if #(
   parameter int VALUE_BITS = 32,
   parameter int ENTRY_BITS = 5
);
   logic                  valid;
   logic                  ready;
   logic                  found;
   logic [VALUE_BITS-1:0] data_out;
   logic [ENTRY_BITS-1:0] entries;

   modport source (output valid, found, data_out, entries, input ready);
   modport sink (input valid, found, data_out, entries, output ready);
   modport monitor (input valid, ready, found, data_out, entries);
endinterface

// ===== src/lkvc_cell.sv =====
module lkvc_cell #(
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lkvc_pkg::lkvc_ctl_type ctl,
   input  logic [KEY_BITS-1:0]    key,
   input  logic [KEY_BITS-1:0]    prev_tag,
   input  logic [VALUE_BITS-1:0]  prev_value,
   input  logic                   prev_valid,
   input  logic                   hit_seen_in,
   input  logic [VALUE_BITS-1:0]  hit_value_in,
   output logic [KEY_BITS-1:0]    tag_out,
   output logic [VALUE_BITS-1:0]  value_out,
   output logic                   valid_out,
   output logic                   hit_seen_out,
   output logic [VALUE_BITS-1:0]  hit_value_out
);
   import lkvc_pkg::*;

   logic [KEY_BITS-1:0]   tag_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  valid_ff;
   logic                  own_hit;
   logic                  shift;

   // entries are kept in recency order: a shift pulls the more recent neighbor in
   assign own_hit       = valid_ff && (tag_ff == key);
   assign shift         = ctl.insert_miss || own_hit || hit_seen_in;
   assign hit_seen_out  = own_hit || hit_seen_in;
   assign hit_value_out = hit_value_in | (own_hit ? value_ff : '0);
   assign tag_out       = tag_ff;
   assign value_out     = value_ff;
   assign valid_out     = valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.advance && shift) begin
         tag_ff   <= prev_tag;
         value_ff <= prev_value;
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance && shift) begin
         valid_ff <= prev_valid;
      end
   end

endmodule

// ===== src/lru_key_value_cache_unit.sv =====
// Latency: a result is presented the cycle after its item is accepted.
// Throughput: one item per cycle while the result side is not stalled; a new item
// is taken while the result register drains. Compare and recency shift happen in one pass of the cell row.
// Reset: synchronous, active high; clears all valid bits and the entry count.
// Tag and value storage is not reset.
module lru_key_value_cache_unit #(
   parameter int CAPACITY   = 16,
   parameter int KEY_BITS   = 64,
   parameter int VALUE_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   lkvc_req_if.sink  req_chan,
   lkvc_rsp_if.source rsp_chan
);
   import lkvc_pkg::*;

   localparam int ENTRY_BITS = $clog2(CAPACITY + 1);

   logic [KEY_BITS-1:0]   link_tag   [CAPACITY+1];
   logic [VALUE_BITS-1:0] link_value [CAPACITY+1];
   logic                  link_valid [CAPACITY+1];
   logic                  hit_seen   [CAPACITY+1];
   logic [VALUE_BITS-1:0] hit_value  [CAPACITY+1];

   lkvc_ctl_type          ctl;
   logic                  accept;
   logic                  hit_any;
   logic [ENTRY_BITS-1:0] count_ff;
   logic [ENTRY_BITS-1:0] count_in;

   logic                  rsp_valid_ff;
   logic                  found_ff;
   logic [VALUE_BITS-1:0] data_ff;
   logic [ENTRY_BITS-1:0] entries_ff;

   assign req_chan.ready  = !rsp_valid_ff || rsp_chan.ready;
   assign accept          = req_chan.valid && req_chan.ready;
   assign hit_any         = hit_seen[0];
   assign ctl.advance     = accept;
   assign ctl.insert_miss = (req_chan.action == ACT_INSERT) && !hit_any;

   assign link_tag[0]   = req_chan.key;
   assign link_value[0] = (req_chan.action == ACT_INSERT) ? req_chan.value : hit_value[0];
   assign link_valid[0] = 1'b1;
   assign hit_seen[CAPACITY]  = 1'b0;
   assign hit_value[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      lkvc_cell #(
         .KEY_BITS   (KEY_BITS),
         .VALUE_BITS (VALUE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .key           (req_chan.key),
         .prev_tag      (link_tag[i]),
         .prev_value    (link_value[i]),
         .prev_valid    (link_valid[i]),
         .hit_seen_in   (hit_seen[i+1]),
         .hit_value_in  (hit_value[i+1]),
         .tag_out       (link_tag[i+1]),
         .value_out     (link_value[i+1]),
         .valid_out     (link_valid[i+1]),
         .hit_seen_out  (hit_seen[i]),
         .hit_value_out (hit_value[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.insert_miss && (count_ff < ENTRY_BITS'(CAPACITY))) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff   <= hit_any;
         data_ff    <= (req_chan.action == ACT_LOOKUP) ? hit_value[0] : '0;
         entries_ff <= count_in;
      end
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = found_ff;
   assign rsp_chan.data_out = data_ff;
   assign rsp_chan.entries  = entries_ff;

endmodule

// ===== src/lkvc_checker.sv =====
module lkvc_checker #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_found,
   input logic [VALUE_BITS-1:0]          rsp_data_out,
   input logic [$clog2(CAPACITY + 1)-1:0] rsp_entries
);
   import lkvc_pkg::*;

   localparam int ENTRY_BITS = $clog2(CAPACITY + 1);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out))
      else $error("result item dropped while stalled");

   a_accept_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_data_out == '0)
      else $error("miss returned nonzero data");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entries <= ENTRY_BITS'(CAPACITY))
      else $error("entry count above capacity");

endmodule

bind lru_key_value_cache_unit lkvc_checker #(
   .CAPACITY   (CAPACITY),
   .VALUE_BITS (VALUE_BITS)
) u_lkvc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_found    (rsp_chan.found),
   .rsp_data_out (rsp_chan.data_out),
   .rsp_entries  (rsp_chan.entries)
);

// ===== tb/sv/tb_lru_key_value_cache_unit.sv =====
module tb_lru_key_value_cache_unit;
   import lkvc_pkg::*;

   localparam int DEPTH       = 16;
   localparam int KEY_W       = 64;
   localparam int VAL_W       = 32;
   localparam int CNT_W       = 5;
   localparam int POOL_SIZE   = 40;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] data;
      logic [CNT_W-1:0] entries;
   } cache_reply_type;

   logic clock;
   logic reset;

   lkvc_req_if #(.KEY_BITS(KEY_W), .VALUE_BITS(VAL_W)) req_chan ();
   lkvc_rsp_if #(.VALUE_BITS(VAL_W), .ENTRY_BITS(CNT_W)) rsp_chan ();

   lru_key_value_cache_unit #(
      .CAPACITY   (DEPTH),
      .KEY_BITS   (KEY_W),
      .VALUE_BITS (VAL_W)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the cache contents
   logic [KEY_W-1:0] sh_tag [DEPTH];
   logic [VAL_W-1:0] sh_val [DEPTH];
   bit               sh_valid [DEPTH];
   int unsigned      sh_rank [DEPTH];
   int unsigned      sh_count;

   cache_reply_type  cache_replies[$];
   logic [KEY_W-1:0] key_pool [POOL_SIZE];
   bit               steady_traffic;
   int               error_count = 0;
   int               cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic cache_reply_type shadow_cache_access(input logic act,
                                                           input logic [KEY_W-1:0] k,
                                                           input logic [VAL_W-1:0] v);
      cache_reply_type r;
      int              hit;
      int              slot;
      r    = '0;
      hit  = -1;
      slot = -1;
      for (int i = 0; i < DEPTH; i++)
         if (hit < 0 && sh_valid[i] && sh_tag[i] == k) hit = i;
      if (hit >= 0) begin
         r.found = 1'b1;
         if (act == ACT_LOOKUP) r.data = sh_val[hit];
         else sh_val[hit] = v;
         for (int i = 0; i < DEPTH; i++)
            if (sh_valid[i] && sh_rank[i] < sh_rank[hit]) sh_rank[i]++;
         sh_rank[hit] = 0;
      end else if (act == ACT_INSERT) begin
         if (sh_count >= DEPTH) begin
            for (int i = 0; i < DEPTH; i++)
               if (sh_valid[i] && sh_rank[i] == DEPTH - 1) slot = i;
            if (slot < 0) slot = 0;
            sh_valid[slot] = 1'b0;
            sh_count = DEPTH - 1;
         end else begin
            for (int i = 0; i < DEPTH; i++)
               if (slot < 0 && !sh_valid[i]) slot = i;
            if (slot < 0) slot = 0;
         end
         for (int i = 0; i < DEPTH; i++)
            if (sh_valid[i]) sh_rank[i]++;
         sh_tag[slot]   = k;
         sh_val[slot]   = v;
         sh_valid[slot] = 1'b1;
         sh_rank[slot]  = 0;
         sh_count++;
      end
      r.entries = sh_count[CNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // result side: random back-pressure (none during steady traffic), compare, then predict newly accepted items
   always @(posedge clock) begin
      cache_reply_type want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sh_count = 0;
         for (int i = 0; i < DEPTH; i++) begin
            sh_valid[i] = 1'b0;
            sh_rank[i]  = 0;
            sh_tag[i]   = '0;
            sh_val[i]   = '0;
         end
         cache_replies.delete();
      end else begin
         rsp_chan.ready <= steady_traffic || ($urandom_range(99) >= 25);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (cache_replies.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_chan.entries), 64'd0);
            end else begin
               want = cache_replies.pop_front();
               if (rsp_chan.found !== want.found)
                  report_mismatch("found", 64'(rsp_chan.found), 64'(want.found));
               if (rsp_chan.data_out !== want.data)
                  report_mismatch("data_out", 64'(rsp_chan.data_out), 64'(want.data));
               if (rsp_chan.entries !== want.entries)
                  report_mismatch("entries", 64'(rsp_chan.entries), 64'(want.entries));
            end
         end
         if (req_chan.valid && req_chan.ready)
            cache_replies.push_back(shadow_cache_access(req_chan.action, req_chan.key,
                                                        req_chan.value));
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_item(input logic act, input logic [KEY_W-1:0] k,
                            input logic [VAL_W-1:0] v);
      while (!steady_traffic && $urandom_range(99) < 25) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.action <= act;
      req_chan.key    <= k;
      req_chan.value  <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      logic [KEY_W-1:0] ones;
      ones = '1;
      send_item(ACT_LOOKUP, '0, '0);
      send_item(ACT_INSERT, '0, '0);
      send_item(ACT_INSERT, ones, '1);
      send_item(ACT_LOOKUP, '0, '1);
      send_item(ACT_LOOKUP, ones, '0);
      send_item(ACT_INSERT, '0, 32'h5a5a_a5a5);   // update of a present key
      send_item(ACT_LOOKUP, '0, '0);
      send_item(ACT_LOOKUP, 64'd1, '0);
      for (int i = 0; i < DEPTH - 2; i++)
         send_item(ACT_INSERT, 64'h100 + i, 32'h1000 + i);
      send_item(ACT_LOOKUP, ones, '0);             // full: promote the oldest
      send_item(ACT_INSERT, 64'hdead_beef_0000_0001, 32'hcafe_0001);  // evicts key 0
      send_item(ACT_LOOKUP, '0, '0);
   endtask

   task automatic run_traffic(input int count, input int pool_used);
      logic [KEY_W-1:0] k;
      logic             act;
      for (int n = 0; n < count; n++) begin
         act = ($urandom_range(99) < 45) ? ACT_INSERT : ACT_LOOKUP;
         if ($urandom_range(9) == 0) k = {$urandom, $urandom};
         else k = key_pool[$urandom_range(pool_used - 1)];
         send_item(act, k, $urandom);
      end
   endtask

   task automatic test_small_working_set();
      run_traffic(400, 8);
   endtask

   task automatic test_near_capacity();
      run_traffic(600, 20);
   endtask

   task automatic test_thrashing();
      run_traffic(500, POOL_SIZE);
   endtask

   task automatic test_back_to_back();
      steady_traffic = 1'b1;
      run_traffic(300, 24);
      steady_traffic = 1'b0;
   endtask

   initial begin
      steady_traffic = 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.action <= ACT_LOOKUP;
      req_chan.key    <= '0;
      req_chan.value  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_small_working_set();
      test_near_capacity();
      test_thrashing();
      test_back_to_back();

      req_chan.valid <= 1'b0;
      while (cache_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
